/* src/kci_pkg.sv */
package kci_pkg;

    localparam int DW = 32;
    localparam int MAX_KEYS_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int AW = 38;

    typedef struct packed {
        logic signed [DW-1:0] t;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        logic signed [DW-1:0] w;
    } t_row;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_BS_ISSUE,
        OP_BS_UPDATE,
        OP_RD_ZERO,
        OP_RD_LAST,
        OP_RD_LO,
        OP_TAKE_ROW,
        OP_WR_OVR,
        OP_INSERT,
        OP_SET_FULL,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_FETCH_INIT,
        OP_FETCH_RD,
        OP_FETCH_CAP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_C_INIT,
        OP_C_MUL,
        OP_C_ADD2,
        OP_C_ADD1,
        OP_C_FIN,
        OP_EMIT
    } t_dp_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_EV_FIRST,
        S_EV_LAST,
        S_BS_CHK,
        S_BS_UPD,
        S_SET_CHK,
        S_SHIFT,
        S_SHIFT_WR,
        S_EV_SEG,
        S_FETCH,
        S_FETCH_CAP,
        S_DIV_INIT,
        S_DIV,
        S_C_INIT,
        S_C_MUL,
        S_C_ADD,
        S_DONE
    } t_state;

    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic is_eval;
        logic n_zero;
        logic n_full;
        logic lo_lt_hi;
        logic lo_lt_n;
        logic j_gt_lo;
        logic rd_lt;
        logic rd_eq;
        logic k_last;
        logic div_last;
        logic comp_last;
        logic spline;
        logic out_busy;
    } t_sts;

    function automatic logic signed [DW-1:0] comp_of(t_row r, logic [1:0] c);
        logic signed [DW-1:0] v;
        case (c)
            2'd0: v = r.x;
            2'd1: v = r.y;
            2'd2: v = r.z;
            default: v = r.w;
        endcase
        return v;
    endfunction

endpackage

/* src/kci_if.sv */
interface kci_in_if import kci_pkg::*; ();
    logic valid;
    logic ready;
    logic opcode;
    logic signed [DW-1:0] time_req;
    logic signed [DW-1:0] value_x;
    logic signed [DW-1:0] value_y;
    logic signed [DW-1:0] value_z;
    logic signed [DW-1:0] value_w;

    modport source (output valid, opcode, time_req, value_x, value_y, value_z, value_w,
                    input ready);
    modport sink (input valid, opcode, time_req, value_x, value_y, value_z, value_w,
                  output ready);
endinterface

interface kci_out_if import kci_pkg::*; ();
    logic valid;
    logic ready;
    logic signed [DW-1:0] out_x;
    logic signed [DW-1:0] out_y;
    logic signed [DW-1:0] out_z;
    logic signed [DW-1:0] out_w;
    logic status;

    modport source (output valid, out_x, out_y, out_z, out_w, status, input ready);
    modport sink (input valid, out_x, out_y, out_z, out_w, status, output ready);
endinterface

/* src/kci_ctrl.sv */
module kci_ctrl import kci_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic [1:0] r_stg, n_stg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stg <= 2'd0;
        end else begin
            r_state <= n_state;
            r_stg <= n_stg;
        end
    end

    always_comb begin
        n_state = r_state;
        n_stg = r_stg;
        o_cmd.op = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_sts.is_eval) begin
                    n_state = S_BS_CHK;
                end else if (i_sts.n_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_RD_ZERO;
                    n_state = S_EV_FIRST;
                end
            end
            S_EV_FIRST: begin
                if (!i_sts.rd_lt) begin
                    o_cmd.op = OP_TAKE_ROW;
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_RD_LAST;
                    n_state = S_EV_LAST;
                end
            end
            S_EV_LAST: begin
                if (i_sts.rd_lt || i_sts.rd_eq) begin
                    o_cmd.op = OP_TAKE_ROW;
                    n_state = S_DONE;
                end else begin
                    n_state = S_BS_CHK;
                end
            end
            S_BS_CHK: begin
                if (i_sts.lo_lt_hi) begin
                    o_cmd.op = OP_BS_ISSUE;
                    n_state = S_BS_UPD;
                end else begin
                    o_cmd.op = OP_RD_LO;
                    n_state = i_sts.is_eval ? S_EV_SEG : S_SET_CHK;
                end
            end
            S_BS_UPD: begin
                o_cmd.op = OP_BS_UPDATE;
                n_state = S_BS_CHK;
            end
            S_SET_CHK: begin
                if (i_sts.lo_lt_n && i_sts.rd_eq) begin
                    o_cmd.op = OP_WR_OVR;
                    n_state = S_DONE;
                end else if (i_sts.n_full) begin
                    o_cmd.op = OP_SET_FULL;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_sts.j_gt_lo) begin
                    o_cmd.op = OP_SHIFT_RD;
                    n_state = S_SHIFT_WR;
                end else begin
                    o_cmd.op = OP_INSERT;
                    n_state = S_DONE;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.op = OP_SHIFT_WR;
                n_state = S_SHIFT;
            end
            S_EV_SEG: begin
                if (i_sts.rd_eq) begin
                    o_cmd.op = OP_TAKE_ROW;
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_FETCH_INIT;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.op = OP_FETCH_RD;
                n_state = S_FETCH_CAP;
            end
            S_FETCH_CAP: begin
                o_cmd.op = OP_FETCH_CAP;
                n_state = i_sts.k_last ? S_DIV_INIT : S_FETCH;
            end
            S_DIV_INIT: begin
                o_cmd.op = OP_DIV_INIT;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_sts.div_last) begin
                    n_state = S_C_INIT;
                end
            end
            S_C_INIT: begin
                o_cmd.op = OP_C_INIT;
                n_stg = 2'd0;
                n_state = S_C_MUL;
            end
            S_C_MUL: begin
                o_cmd.op = OP_C_MUL;
                n_state = S_C_ADD;
            end
            S_C_ADD: begin
                if (!i_sts.spline || r_stg == 2'd2) begin
                    o_cmd.op = OP_C_FIN;
                    n_state = i_sts.comp_last ? S_DONE : S_C_INIT;
                end else begin
                    o_cmd.op = (r_stg == 2'd0) ? OP_C_ADD2 : OP_C_ADD1;
                    n_stg = r_stg + 2'd1;
                    n_state = S_C_MUL;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* src/kci_dp.sv */
module kci_dp import kci_pkg::*; #(
    parameter int MAX_KEYS = MAX_KEYS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    input  logic                 i_opcode,
    input  logic signed [DW-1:0] i_time_req,
    input  logic signed [DW-1:0] i_value_x,
    input  logic signed [DW-1:0] i_value_y,
    input  logic signed [DW-1:0] i_value_z,
    input  logic signed [DW-1:0] i_value_w,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic signed [DW-1:0] o_out_x,
    output logic signed [DW-1:0] o_out_y,
    output logic signed [DW-1:0] o_out_z,
    output logic signed [DW-1:0] o_out_w,
    output logic                 o_status,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts
);

    localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int FW = FRAC_BITS;
    localparam int DCW = $clog2(FRAC_BITS);
    localparam int PW = AW + FW + 1;

    t_row r_mem [MAX_KEYS];
    t_row r_rd;
    t_row r_req;
    t_row r_pt [4];
    logic r_eval;
    logic r_mode;
    logic [CW-1:0] r_n, r_lo, r_hi, r_mid, r_j;
    logic [1:0] r_k, r_comp;
    logic [DW:0] r_den, r_rem;
    logic [FW-1:0] r_f;
    logic [DCW-1:0] r_dcnt;
    logic signed [AW-1:0] r_acc, r_h;
    logic [DW-1:0] r_res [4];
    logic r_stat;
    logic [DW-1:0] r_out [4];
    logic r_ostat;
    logic r_ov;

    logic [CW:0] w_sum, w_lo1, w_lo2;
    logic [CW-1:0] w_mid, w_raddr, w_waddr, w_faddr;
    logic w_re, w_we;
    t_row w_wdata;
    logic [DW+1:0] w_rem2, w_diff;
    logic w_ge;
    logic signed [AW-1:0] w_p0, w_p1, w_p2, w_p3, w_c3, w_c2, w_c1;
    logic signed [PW-1:0] w_prod, w_sh;
    logic signed [AW:0] w_lin, w_spl;

    function automatic logic [DW-1:0] sat(logic signed [AW:0] v);
        logic [DW-1:0] r;
        if (v > (AW+1)'(signed'({1'b0, {(DW-1){1'b1}}}))) begin
            r = {1'b0, {(DW-1){1'b1}}};
        end else if (v < -(AW+1)'(signed'({1'b0, 1'b1, {(DW-1){1'b0}}}))) begin
            r = {1'b1, {(DW-1){1'b0}}};
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[CW:1];
    assign w_lo1 = {1'b0, r_lo} + (CW+1)'(1);
    assign w_lo2 = {1'b0, r_lo} + (CW+1)'(2);

    always_comb begin
        case (r_k)
            2'd0: w_faddr = (r_lo != '0) ? r_lo - CW'(1) : r_lo;
            2'd1: w_faddr = r_lo;
            2'd2: w_faddr = w_lo1[CW-1:0];
            default: w_faddr = (w_lo2 < {1'b0, r_n}) ? w_lo2[CW-1:0] : w_lo1[CW-1:0];
        endcase
    end

    always_comb begin
        w_re = 1'b1;
        case (i_cmd.op)
            OP_BS_ISSUE: w_raddr = w_mid;
            OP_RD_ZERO: w_raddr = '0;
            OP_RD_LAST: w_raddr = r_n - CW'(1);
            OP_RD_LO: w_raddr = r_lo;
            OP_SHIFT_RD: w_raddr = r_j - CW'(1);
            OP_FETCH_RD: w_raddr = w_faddr;
            default: begin
                w_raddr = '0;
                w_re = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_we = 1'b0;
        w_waddr = r_lo;
        w_wdata = r_req;
        case (i_cmd.op)
            OP_WR_OVR, OP_INSERT: w_we = 1'b1;
            OP_SHIFT_WR: begin
                w_we = 1'b1;
                w_waddr = r_j;
                w_wdata = r_rd;
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr[IW-1:0]] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[w_raddr[IW-1:0]];
        end
    end

    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge = w_rem2 >= {1'b0, r_den};
    assign w_diff = w_rem2 - {1'b0, r_den};

    assign w_p0 = AW'(comp_of(r_pt[0], r_comp));
    assign w_p1 = AW'(comp_of(r_pt[1], r_comp));
    assign w_p2 = AW'(comp_of(r_pt[2], r_comp));
    assign w_p3 = AW'(comp_of(r_pt[3], r_comp));
    assign w_c3 = w_p3 - w_p0 + 3 * w_p1 - 3 * w_p2;
    assign w_c2 = 2 * w_p0 - 5 * w_p1 + 4 * w_p2 - w_p3;
    assign w_c1 = w_p2 - w_p0;
    assign w_prod = PW'(r_acc) * signed'({1'b0, r_f});
    assign w_sh = w_prod >>> FW;
    assign w_lin = (AW+1)'(r_h) + (AW+1)'(w_p1);
    assign w_spl = ((AW+1)'(r_h) + ((AW+1)'(w_p1) <<< 1)) >>> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
            r_mode <= 1'b1;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (i_cmd.op == OP_INSERT) begin
                r_n <= r_n + CW'(1);
            end
            if (i_cmd.op == OP_EMIT) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_eval <= i_opcode;
                r_req <= '{t: i_time_req, x: i_value_x, y: i_value_y, z: i_value_z,
                           w: i_value_w};
                r_lo <= '0;
                r_hi <= r_n;
                r_j <= r_n;
                r_comp <= 2'd0;
                r_stat <= 1'b0;
                for (int i = 0; i < 4; i++) begin
                    r_res[i] <= '0;
                end
            end
            OP_BS_ISSUE: r_mid <= w_mid;
            OP_BS_UPDATE: begin
                if (o_sts.rd_lt) begin
                    r_lo <= r_mid + CW'(1);
                end else begin
                    r_hi <= r_mid;
                end
            end
            OP_TAKE_ROW: begin
                r_res[0] <= r_rd.x;
                r_res[1] <= r_rd.y;
                r_res[2] <= r_rd.z;
                r_res[3] <= r_rd.w;
            end
            OP_SET_FULL: r_stat <= 1'b1;
            OP_SHIFT_WR: r_j <= r_j - CW'(1);
            OP_FETCH_INIT: begin
                r_lo <= r_lo - CW'(1);
                r_k <= 2'd0;
            end
            OP_FETCH_CAP: begin
                r_pt[r_k] <= r_rd;
                r_k <= r_k + 2'd1;
            end
            OP_DIV_INIT: begin
                r_den <= {r_pt[2].t[DW-1], r_pt[2].t} - {r_pt[1].t[DW-1], r_pt[1].t};
                r_rem <= {r_req.t[DW-1], r_req.t} - {r_pt[1].t[DW-1], r_pt[1].t};
                r_f <= '0;
                r_dcnt <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= w_ge ? w_diff[DW:0] : w_rem2[DW:0];
                r_f <= {r_f[FW-2:0], w_ge};
                r_dcnt <= r_dcnt + DCW'(1);
            end
            OP_C_INIT: r_acc <= o_sts.spline ? w_c3 : w_p2 - w_p1;
            OP_C_MUL: r_h <= w_sh[AW-1:0];
            OP_C_ADD2: r_acc <= r_h + w_c2;
            OP_C_ADD1: r_acc <= r_h + w_c1;
            OP_C_FIN: begin
                r_res[r_comp] <= o_sts.spline ? sat(w_spl) : sat(w_lin);
                r_comp <= r_comp + 2'd1;
            end
            OP_EMIT: begin
                r_out <= r_res;
                r_ostat <= r_stat;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    always_comb begin
        o_sts.is_eval = r_eval;
        o_sts.n_zero = (r_n == '0);
        o_sts.n_full = (r_n >= CW'(MAX_KEYS));
        o_sts.lo_lt_hi = (r_lo < r_hi);
        o_sts.lo_lt_n = (r_lo < r_n);
        o_sts.j_gt_lo = (r_j > r_lo);
        o_sts.rd_lt = (r_rd.t < r_req.t);
        o_sts.rd_eq = (r_rd.t == r_req.t);
        o_sts.k_last = (r_k == 2'd3);
        o_sts.div_last = (r_dcnt == DCW'(FRAC_BITS - 1));
        o_sts.comp_last = (r_comp == 2'd3);
        o_sts.spline = r_mode && (r_n >= CW'(3));
        o_sts.out_busy = r_ov && !i_out_ready;
    end

    assign o_out_valid = r_ov;
    assign o_out_x = r_out[0];
    assign o_out_y = r_out[1];
    assign o_out_z = r_out[2];
    assign o_out_w = r_out[3];
    assign o_status = r_ostat;

endmodule

/* src/keyframe_curve_interpolator.sv */
// Keyframe curve interpolator with a sorted table of up to MAX_KEYS keys.
// Items arrive on i_item with a valid and ready handshake. Opcode 0 sets a
// key at time_req, overwriting an equal time or inserting in order. Opcode 1
// evaluates the curve at time_req. Each item gives one result on o_result.
// The block works on one item at a time; ready is high only while idle.
// A set item runs a binary search, then overwrites a key or moves later keys up.
// An evaluate item runs a binary search, fetches four keys, then uses the
// bit-serial divider and the shared multiplier, which in spline mode runs three
// passes per component; the ends of the curve skip this work.
// The result waits in an output register, so the next item is accepted while
// the previous result is not yet taken; a new result waits until it is.
// Reset empties the table and selects spline mode; the key memory itself
// is not cleared. i_cfg_wr_en with i_cfg_wr_data writes the mode bit; the user
// is to write it only while the block is idle, and the block has no guard for this.
module keyframe_curve_interpolator import kci_pkg::*; #(
    parameter int MAX_KEYS = MAX_KEYS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    kci_in_if.sink    i_item,
    kci_out_if.source o_result
);

    t_cmd w_cmd;
    t_sts w_sts;

    kci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    kci_dp #(
        .MAX_KEYS  (MAX_KEYS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_opcode      (i_item.opcode),
        .i_time_req    (i_item.time_req),
        .i_value_x     (i_item.value_x),
        .i_value_y     (i_item.value_y),
        .i_value_z     (i_item.value_z),
        .i_value_w     (i_item.value_w),
        .i_out_ready   (o_result.ready),
        .o_out_valid   (o_result.valid),
        .o_out_x       (o_result.out_x),
        .o_out_y       (o_result.out_y),
        .o_out_z       (o_result.out_z),
        .o_out_w       (o_result.out_w),
        .o_status      (o_result.status),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts)
    );

endmodule

/* src/kci_checker.sv */
module kci_checker import kci_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic [DW-1:0] i_out_x
);

    // One item is worked on at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while another is in progress");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("block not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_x))
        else $error("result changed while stalled");

endmodule

bind keyframe_curve_interpolator kci_checker u_kci_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_x     (o_result.out_x)
);
